>>> rtl/core/ledblk_pkg.sv
// Shared constants and types for the multi-LED blink/toggle controller.
// No dependencies; used by the channel interfaces and the top level.
package ledblk_pkg;

  localparam int NUM_LEDS  = 2;
  localparam int TIME_BITS = 16;

  // Payload widths fixed by the item format
  localparam int IDX_W   = 4;
  localparam int TICKS_W = 16;
  localparam int OUT_W   = 2;

  localparam int LED_IDX_W = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
  localparam int OUT_IDX_W = (OUT_W > 1) ? $clog2(OUT_W) : 1;

  // Reset values of the blink times
  localparam int ON_TIME_RST       = 1;
  localparam int OFF_TIME_RST_LED0 = 199;
  localparam int OFF_TIME_RST_REST = 99;

  typedef enum logic [1:0] {
    MODE_ON_OFF   = 2'd0,
    MODE_TOGGLE   = 2'd1,
    MODE_BLINK    = 2'd2,
    MODE_DISABLED = 2'd3
  } led_mode_t;

  typedef enum logic {
    CMD_TICK = 1'b0,
    CMD_SET  = 1'b1
  } cmd_t;

endpackage

>>> rtl/core/ledblk_if.sv
// Valid/ready channel interfaces for the LED controller: command in, drive result out.
// Depends on ledblk_pkg for payload widths.
interface ledblk_in_if;
  logic                               valid;
  logic                               ready;
  logic                               mode;
  logic [ledblk_pkg::IDX_W-1:0]       led_index;
  logic [1:0]                         led_mode;
  logic                               led_enable;
  logic [ledblk_pkg::TICKS_W-1:0]     interval_ticks;
  logic [ledblk_pkg::TICKS_W-1:0]     on_ticks;
  logic [ledblk_pkg::TICKS_W-1:0]     off_ticks;

  modport source (output valid, mode, led_index, led_mode, led_enable,
                  interval_ticks, on_ticks, off_ticks, input ready);
  modport sink   (input valid, mode, led_index, led_mode, led_enable,
                  interval_ticks, on_ticks, off_ticks, output ready);
endinterface

interface ledblk_out_if;
  logic                          valid;
  logic                          ready;
  logic [ledblk_pkg::OUT_W-1:0]  drive_mask;
  logic [ledblk_pkg::OUT_W-1:0]  drive_level;

  modport source (output valid, drive_mask, drive_level, input ready);
  modport sink   (input valid, drive_mask, drive_level, output ready);
endinterface

>>> rtl/core/multi_led_blink_toggle_controller.sv
// Top level of the multi-LED blink/toggle controller.
// Depends on ledblk_pkg and the channel interfaces in ledblk_if.sv.
//
// Each accepted transaction yields exactly one result transaction. A set command
// goes from idle straight to the done state, where its result is loaded into the
// output register. A tick first passes through the step state, where one shared
// decrement/reload unit visits the LED entries one per cycle, and then reaches the
// done state and loads its result. While the output register holds a result that
// the receiver has not taken, the sequencer waits in its done state. The input is
// ready whenever the sequencer is idle, even while a previous result still waits
// in the output register.
module multi_led_blink_toggle_controller (
  input  logic                  clk,
  input  logic                  rst,
  ledblk_in_if.sink             in_ch,
  ledblk_out_if.source          out_ch
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEP,
    ST_DONE
  } state_t;

  localparam int LIDX = ledblk_pkg::LED_IDX_W;
  localparam int TB   = ledblk_pkg::TIME_BITS;
  localparam int OW   = ledblk_pkg::OUT_W;

  state_t state;
  logic [LIDX-1:0] ptr;
  logic [OW-1:0]   mask_acc;
  logic [OW-1:0]   level_acc;
  logic            out_valid;
  logic [OW-1:0]   out_mask;
  logic [OW-1:0]   out_level;

  // Per-LED stores
  ledblk_pkg::led_mode_t mode_store   [ledblk_pkg::NUM_LEDS];
  logic                  enable_store [ledblk_pkg::NUM_LEDS];
  logic [TB-1:0]         interval_store [ledblk_pkg::NUM_LEDS];
  logic [TB-1:0]         on_store     [ledblk_pkg::NUM_LEDS];
  logic [TB-1:0]         off_store    [ledblk_pkg::NUM_LEDS];
  logic [TB-1:0]         cd_store     [ledblk_pkg::NUM_LEDS];
  logic                  tl_store     [ledblk_pkg::NUM_LEDS];

  logic in_fire;
  logic set_fire;
  logic set_hit;
  logic [LIDX-1:0] set_idx;
  logic out_free;
  logic load_out;
  logic last_led;

  // Shared step unit signals
  ledblk_pkg::led_mode_t cur_mode;
  logic          cur_en;
  logic          cur_tl;
  logic [TB-1:0] cur_cd;
  logic [TB-1:0] interval_next;
  logic [TB-1:0] cd_next;
  logic          tl_next;
  logic          drive;
  logic          drive_lv;
  logic          in_out_range;
  logic [ledblk_pkg::OUT_IDX_W-1:0] out_bit;

  assign in_ch.ready = (state == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign set_fire    = in_fire && (in_ch.mode == ledblk_pkg::CMD_SET);
  assign set_hit     = set_fire && ({1'b0, in_ch.led_index} <
                                    (ledblk_pkg::IDX_W + 1)'(ledblk_pkg::NUM_LEDS));
  assign set_idx     = in_ch.led_index[LIDX-1:0];
  assign out_free    = !out_valid || out_ch.ready;
  assign load_out    = (state == ST_DONE) && out_free;
  assign last_led    = (ptr == LIDX'(ledblk_pkg::NUM_LEDS - 1));

  assign out_ch.valid       = out_valid;
  assign out_ch.drive_mask  = out_mask;
  assign out_ch.drive_level = out_level;

  assign cur_mode = mode_store[ptr];
  assign cur_en   = enable_store[ptr];
  assign cur_tl   = tl_store[ptr];
  assign cur_cd   = cd_store[ptr];

  assign in_out_range = ({1'b0, ptr} < (LIDX + 1)'(OW));
  assign out_bit      = ledblk_pkg::OUT_IDX_W'(ptr);

  always_comb begin
    interval_next = interval_store[ptr];
    tl_next       = cur_tl;
    cd_next       = cur_cd - TB'(1);
    drive         = 1'b0;
    drive_lv      = 1'b0;
    if (cur_cd == '0) begin
      case (cur_mode)
        ledblk_pkg::MODE_ON_OFF: begin
          drive    = 1'b1;
          drive_lv = cur_en;
        end
        ledblk_pkg::MODE_TOGGLE, ledblk_pkg::MODE_BLINK: begin
          // Blink picks the next phase length before flipping the level
          if (cur_mode == ledblk_pkg::MODE_BLINK) begin
            interval_next = cur_tl ? off_store[ptr] : on_store[ptr];
          end
          tl_next  = ~cur_tl;
          drive    = 1'b1;
          drive_lv = cur_en & ~cur_tl;
        end
        default: begin
        end
      endcase
      cd_next = interval_next;
    end
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ptr       <= '0;
      mask_acc  <= '0;
      level_acc <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            ptr       <= '0;
            mask_acc  <= '0;
            level_acc <= '0;
            state     <= (in_ch.mode == ledblk_pkg::CMD_SET) ? ST_DONE : ST_STEP;
          end
        end
        ST_STEP: begin
          if (drive && in_out_range) begin
            mask_acc[out_bit]  <= 1'b1;
            level_acc[out_bit] <= drive_lv;
          end
          ptr <= ptr + LIDX'(1);
          if (last_led) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          // Hold until the output register frees up
          if (load_out) begin
            out_mask  <= mask_acc;
            out_level <= level_acc;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // LED state stores
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ledblk_pkg::NUM_LEDS; i++) begin
        mode_store[i]     <= ledblk_pkg::MODE_BLINK;
        enable_store[i]   <= (i == 0);
        interval_store[i] <= '0;
        on_store[i]       <= TB'(ledblk_pkg::ON_TIME_RST);
        off_store[i]      <= (i == 0) ? TB'(ledblk_pkg::OFF_TIME_RST_LED0)
                                      : TB'(ledblk_pkg::OFF_TIME_RST_REST);
        cd_store[i]       <= '0;
        tl_store[i]       <= 1'b0;
      end
    end else if (set_hit) begin
      mode_store[set_idx]   <= ledblk_pkg::led_mode_t'(in_ch.led_mode);
      enable_store[set_idx] <= in_ch.led_enable;
      tl_store[set_idx]     <= in_ch.led_enable;
      if (in_ch.led_mode == ledblk_pkg::MODE_BLINK ||
          in_ch.led_mode == ledblk_pkg::MODE_TOGGLE) begin
        interval_store[set_idx] <= TB'(in_ch.interval_ticks);
      end
      if (in_ch.led_mode == ledblk_pkg::MODE_BLINK) begin
        on_store[set_idx]  <= TB'(in_ch.on_ticks);
        off_store[set_idx] <= TB'(in_ch.off_ticks);
        cd_store[set_idx]  <= TB'(in_ch.interval_ticks);
      end
    end else if (state == ST_STEP) begin
      interval_store[ptr] <= interval_next;
      tl_store[ptr]       <= tl_next;
      cd_store[ptr]       <= cd_next;
    end
  end

endmodule
